### hdl/motor_can_command_encoder_unit_macros.svh
// Assertion macros shared by the motor command encoder RTL.
`ifndef MOTOR_CAN_COMMAND_ENCODER_UNIT_MACROS_SVH
`define MOTOR_CAN_COMMAND_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define MCCE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcce: same-cycle check failed");

// Next-cycle implication, clocked on clk_i and quiet while rst_ni is low.
`define MCCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcce: next-cycle check failed");

`endif

### hdl/mcce_pkg.sv
// Types and constants of the motor command encoder.
package mcce_pkg;

  typedef enum logic [2:0] {
    CMD_DUTY      = 3'd0,
    CMD_CURRENT   = 3'd1,
    CMD_BRAKE     = 3'd2,
    CMD_SPEED     = 3'd3,
    CMD_POSITION  = 3'd4,
    CMD_ORIGIN    = 3'd5,
    CMD_POS_SPEED = 3'd6,
    CMD_ATTACH    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_RP,
    STEP_MUL,
    STEP_SHIFT,
    STEP_CLAMP
  } step_e;

  localparam int MulAW = 32;
  localparam int MulBW = 25;
  localparam int ProdW = MulAW + MulBW;

  localparam logic [1:0] PASS_WORD  = 2'd0;
  localparam logic [1:0] PASS_SPEED = 2'd1;
  localparam logic [1:0] PASS_ACCEL = 2'd2;

  localparam logic [3:0] LEN_ONE   = 4'd1;
  localparam logic [3:0] LEN_FOUR  = 4'd4;
  localparam logic [3:0] LEN_EIGHT = 4'd8;

  localparam logic signed [MulBW-1:0] DUTY_SCALE     = 25'sd100000;
  localparam logic signed [MulBW-1:0] CURRENT_SCALE  = 25'sd1000;
  localparam logic signed [MulBW-1:0] POSITION_SCALE = 25'sd10000;
  localparam logic signed [31:0]      DUTY_MAX       = 32'sd65536;

  // Rounding offsets that make the arithmetic shifts truncate toward zero.
  localparam logic signed [ProdW-1:0] BIAS_Q8  = 57'sd255;
  localparam logic signed [ProdW-1:0] BIAS_Q16 = 57'sd65535;
  localparam logic signed [ProdW-1:0] BIAS_Q24 = 57'sd16777215;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         motor_id;
    logic signed [31:0] value;
    logic signed [15:0] speed_limit;
    logic signed [15:0] accel_limit;
    logic [7:0]         origin_mode;
    logic [15:0]        gear_ratio;
    logic [7:0]         pole_pairs;
    logic [15:0]        max_current_ma;
  } mcce_req_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] payload;
  } mcce_res_t;

  typedef struct packed {
    logic [15:0] ratio;
    logic [7:0]  poles;
    logic [15:0] limit_ma;
  } profile_t;

  localparam profile_t DEF_PROFILE = '{ratio: 16'd256, poles: 8'd1, limit_ma: 16'd10000};

  typedef struct packed {
    step_e      step;
    logic [1:0] pass;
    logic       fin;
  } ctrl_t;

endpackage

### hdl/mcce_mul.sv
// Shared signed multiplier with a registered product.
module mcce_mul (
  input  logic                                 clk_i,
  input  logic signed [mcce_pkg::MulAW-1:0]    a_i,
  input  logic signed [mcce_pkg::MulBW-1:0]    b_i,
  output logic signed [mcce_pkg::ProdW-1:0]    prod_o
);
  import mcce_pkg::*;

  logic signed [ProdW-1:0] prod_d, prod_q;

  assign prod_d = ProdW'(a_i) * ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

### hdl/mcce_profile_store.sv
// Per-id motor profile memory with reset-cleared attach flags.
module mcce_profile_store #(
  parameter int MOTOR_IDS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic                rd_en_i,
  input  logic [7:0]          id_i,
  input  mcce_pkg::profile_t  wr_data_i,
  output mcce_pkg::profile_t  rd_data_o
);
  import mcce_pkg::*;

  localparam int IdxW = (MOTOR_IDS > 1) ? $clog2(MOTOR_IDS) : 1;

  profile_t mem [MOTOR_IDS];
  logic [MOTOR_IDS-1:0] attached_q;
  profile_t rd_q;
  logic hit_q;
  logic in_range;
  logic [IdxW-1:0] idx;

  assign in_range = {1'b0, id_i} < 9'(MOTOR_IDS);
  assign idx      = id_i[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      mem[idx] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attached_q <= '0;
      hit_q      <= 1'b0;
    end else begin
      if (wr_en_i && in_range) begin
        attached_q[idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= in_range && attached_q[idx];
      end
    end
  end

  // Ids that were never attached fall back to the default profile.
  assign rd_data_o = hit_q ? rd_q : DEF_PROFILE;

endmodule

### hdl/mcce_ctrl.sv
// Sequencer that steps one request through the shared multiplier.
module mcce_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic            multi_i,
  output mcce_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import mcce_pkg::*;

  step_e      step_q, step_d;
  logic [1:0] pass_q, pass_d;
  logic       fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      pass_q <= PASS_WORD;
    end else begin
      step_q <= step_d;
      pass_q <= pass_d;
    end
  end

  always_comb begin
    step_d = step_q;
    pass_d = pass_q;
    fin    = 1'b0;
    case (step_q)
      STEP_IDLE: begin
        pass_d = PASS_WORD;
        if (go_i) begin
          step_d = STEP_RP;
        end
      end
      STEP_RP:    step_d = STEP_MUL;
      STEP_MUL:   step_d = STEP_SHIFT;
      STEP_SHIFT: step_d = STEP_CLAMP;
      STEP_CLAMP: begin
        // Position-with-speed runs two more passes for its limit fields.
        if (multi_i && pass_q != PASS_ACCEL) begin
          pass_d = pass_q + 2'd1;
          step_d = STEP_MUL;
        end else begin
          pass_d = PASS_WORD;
          step_d = STEP_IDLE;
          fin    = 1'b1;
        end
      end
      default: begin
        step_d = STEP_IDLE;
        pass_d = PASS_WORD;
      end
    endcase
  end

  assign ctrl_o = '{step: step_q, pass: pass_q, fin: fin};
  assign busy_o = step_q != STEP_IDLE;

endmodule

### hdl/motor_can_command_encoder_unit.sv
// Top level of the motor command to CAN frame encoder.
//
//   port group        dir  handshake          contents
//   start/req_i       in   start && !busy     command request (mcce_req_t)
//   done_o/res_o      out  done_o, one cycle  CAN frame (mcce_res_t)
//
// A frame request keeps busy high for one gain product, then multiply, rounding shift and clamp
// passes through the shared multiplier; position-with-speed repeats them for both limit fields.
// done_o pulses in the cycle after the last pass, and a new request is taken in that cycle.
// Attach requests write the profile memory in the accept cycle and leave busy low.
// Reset clears the sequencer, the strobe and all attach flags at once.
// Results cannot be stalled; each one is valid only while done_o is high.
module motor_can_command_encoder_unit #(
  parameter int MOTOR_IDS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  mcce_pkg::mcce_req_t req_i,
  output logic                done_o,
  output mcce_pkg::mcce_res_t res_o
);
  import mcce_pkg::*;

`include "motor_can_command_encoder_unit_macros.svh"

  ctrl_t ctrl;
  logic accept, go, attach;

  mcce_req_t  req_q;
  profile_t   prof;
  profile_t   wr_prof;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] bias_w, sum_w, shifted_w;
  logic [23:0] rp_q, rp_w;
  logic signed [31:0] vclamp_q, vclamp_d;
  logic signed [31:0] sh_q, lim_w, lo_w, word_w;
  logic [63:0] payload_q, payload_d;
  logic done_q;
  logic len_ok;

  assign accept = start && !busy;
  assign attach = req_i.cmd == CMD_ATTACH;
  assign go     = accept && !attach;

  assign wr_prof = '{ratio: req_i.gear_ratio, poles: req_i.pole_pairs,
                     limit_ma: req_i.max_current_ma};

  mcce_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .multi_i (req_q.cmd == CMD_POS_SPEED),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  mcce_profile_store #(.MOTOR_IDS(MOTOR_IDS)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && attach),
    .rd_en_i   (go),
    .id_i      (req_i.motor_id),
    .wr_data_i (wr_prof),
    .rd_data_o (prof)
  );

  mcce_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // The first multiply pass finds ratio times pole pairs still in the product.
  assign rp_w = (ctrl.pass == PASS_WORD) ? prod[23:0] : rp_q;

  always_comb begin
    if (req_q.value > DUTY_MAX) begin
      vclamp_d = DUTY_MAX;
    end else if (req_q.value < -DUTY_MAX) begin
      vclamp_d = -DUTY_MAX;
    end else begin
      vclamp_d = req_q.value;
    end
  end

  always_comb begin
    mul_a = req_q.value;
    mul_b = POSITION_SCALE;
    if (ctrl.step == STEP_RP) begin
      mul_a = signed'({16'b0, prof.ratio});
      mul_b = signed'({17'b0, prof.poles});
    end else begin
      case (req_q.cmd)
        CMD_DUTY: begin
          mul_a = vclamp_q;
          mul_b = DUTY_SCALE;
        end
        CMD_CURRENT, CMD_BRAKE: mul_b = CURRENT_SCALE;
        CMD_SPEED:              mul_b = signed'({1'b0, rp_w});
        CMD_POS_SPEED: begin
          if (ctrl.pass == PASS_SPEED) begin
            mul_a = 32'(req_q.speed_limit);
            mul_b = signed'({1'b0, rp_w});
          end else if (ctrl.pass == PASS_ACCEL) begin
            mul_a = 32'(req_q.accel_limit);
            mul_b = signed'({1'b0, rp_w});
          end
        end
        default: mul_b = POSITION_SCALE;
      endcase
    end
  end

  // Divide by a power of two with truncation toward zero.
  always_comb begin
    bias_w    = '0;
    sum_w     = '0;
    shifted_w = '0;
    if (req_q.cmd == CMD_SPEED) begin
      bias_w    = prod[ProdW-1] ? BIAS_Q24 : '0;
      sum_w     = prod + bias_w;
      shifted_w = sum_w >>> 24;
    end else if (req_q.cmd == CMD_POS_SPEED && ctrl.pass != PASS_WORD) begin
      bias_w    = prod[ProdW-1] ? BIAS_Q8 : '0;
      sum_w     = prod + bias_w;
      shifted_w = sum_w >>> 8;
    end else begin
      bias_w    = prod[ProdW-1] ? BIAS_Q16 : '0;
      sum_w     = prod + bias_w;
      shifted_w = sum_w >>> 16;
    end
  end

  always_comb begin
    lim_w  = signed'({16'b0, prof.limit_ma});
    lo_w   = (req_q.cmd == CMD_BRAKE) ? 32'sd0 : -lim_w;
    word_w = sh_q;
    if (req_q.cmd == CMD_CURRENT || req_q.cmd == CMD_BRAKE) begin
      if (sh_q > lim_w) begin
        word_w = lim_w;
      end else if (sh_q < lo_w) begin
        word_w = lo_w;
      end
    end
    payload_d = payload_q;
    case (ctrl.pass)
      PASS_SPEED: payload_d[31:16] = sh_q[15:0];
      PASS_ACCEL: payload_d[15:0]  = sh_q[15:0];
      default: begin
        if (req_q.cmd == CMD_ORIGIN) begin
          payload_d = {req_q.origin_mode, 56'b0};
        end else begin
          payload_d = {word_w, 32'b0};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.step == STEP_RP) begin
      vclamp_q <= vclamp_d;
    end
    if (ctrl.step == STEP_MUL) begin
      rp_q <= rp_w;
    end
    if (ctrl.step == STEP_SHIFT) begin
      sh_q <= shifted_w[31:0];
    end
    if (ctrl.step == STEP_CLAMP) begin
      payload_q <= payload_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl.fin;
    end
  end

  assign done_o             = done_q;
  assign res_o.frame_id     = {req_q.cmd, req_q.motor_id};
  assign res_o.frame_length = (req_q.cmd == CMD_ORIGIN)    ? LEN_ONE :
                              (req_q.cmd == CMD_POS_SPEED) ? LEN_EIGHT : LEN_FOUR;
  assign res_o.payload      = payload_q;

  assign len_ok = res_o.frame_length == LEN_ONE || res_o.frame_length == LEN_FOUR ||
                  res_o.frame_length == LEN_EIGHT;

  `MCCE_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `MCCE_ASSERT_NEXT(a_frame_goes_busy, start && !busy && req_i.cmd != CMD_ATTACH, busy)
  `MCCE_ASSERT_NEXT(a_attach_silent, start && !busy && req_i.cmd == CMD_ATTACH, !busy && !done_o)
  `MCCE_ASSERT_IMPL(a_len_legal, done_o, len_ok)

endmodule
